### src/csf_pkg.sv
// Shared types, constants and helpers of the circle scanline fill unit.
`default_nettype none

package csf_pkg;

  localparam int ROWS_DEF = 512;

  localparam int COL_W   = 9;
  localparam int LEFT_W  = 10;
  localparam int ENTRY_W = LEFT_W + COL_W;
  localparam int COORD_W = 14;

  localparam logic [LEFT_W-1:0]  EMPTY_LEFT  = 10'd512;
  localparam logic [COL_W-1:0]   ZERO_RIGHT  = 9'd0;
  localparam logic [COL_W-1:0]   COL_MAX     = 9'd511;
  localparam logic [ENTRY_W-1:0] ENTRY_EMPTY = {EMPTY_LEFT, ZERO_RIGHT};

  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One octant point of the midpoint walk.
  typedef struct packed {
    logic             valid;
    logic             last;
    coord_t           row;
    logic [COL_W-1:0] col;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WALK,
    ST_DRAIN,
    ST_RESP
  } state_t;

  function automatic logic [LEFT_W-1:0] entry_left(input logic [ENTRY_W-1:0] e);
    return e[ENTRY_W-1:COL_W];
  endfunction

  function automatic logic [COL_W-1:0] entry_right(input logic [ENTRY_W-1:0] e);
    return e[COL_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/csf_if.sv
// Valid/ready channel interfaces for draw/read commands and span results.
`default_nettype none

interface csf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [8:0] center_x;
  logic [8:0] center_y;
  logic [8:0] radius;
  logic [8:0] row;

  modport source (output valid, output kind, output center_x, output center_y,
                  output radius, output row, input ready);
  modport sink   (input valid, input kind, input center_x, input center_y,
                  input radius, input row, output ready);
endinterface

interface csf_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] span_left;
  logic [8:0] span_right;
  logic       span_present;

  modport source (output valid, output span_left, output span_right,
                  output span_present, input ready);
  modport sink   (input valid, input span_left, input span_right,
                  input span_present, output ready);
endinterface

`default_nettype wire

### src/circle_scanline_fill_unit.sv
// Top level of the circle scanline fill unit: control, edge table and result register.
`default_nettype none

// Keeps a left and a right edge for each of ROWS scanlines in one RAM entry
// ({left, right}). A draw word clears all ROWS entries, one per cycle, then
// walks the midpoint circle and runs one octant point per cycle through a
// read-modify-write pipe on the RAM. A read word goes through a RAM read,
// then the result register, which also waits on out_ch.ready. A new word is
// taken only when the unit is idle; a draw may be taken while a read result
// still waits. Rows outside 0..ROWS-1 are dropped by the draw and read back
// as empty (left 512, right 0, no span). Until the first draw after reset
// every read answers empty; no clearing pass runs after reset.
module circle_scanline_fill_unit #(
  parameter int ROWS = csf_pkg::ROWS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  csf_in_if.sink    in_ch,
  csf_out_if.source out_ch
);

  localparam int AW = $clog2(ROWS);
  localparam csf_pkg::coord_t ROWS_C = csf_pkg::coord_t'(ROWS);

  csf_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]             clr_cnt_r, clr_cnt_nxt;
  logic                      drawn_r, drawn_nxt;
  logic [8:0]                cx_r, cy_r, rad_r;
  logic [AW-1:0]             row_r;
  logic                      oob_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [csf_pkg::LEFT_W-1:0] span_left_r;
  logic [csf_pkg::COL_W-1:0]  span_right_r;
  logic                      span_present_r;

  logic                        in_acc;
  logic                        out_free;
  logic                        walk_start;
  csf_pkg::point_t             pt;
  logic                        pt_drop;
  logic                        iss_we;
  logic                        upd_we;
  logic [AW-1:0]               upd_waddr;
  logic [csf_pkg::ENTRY_W-1:0] upd_wdata;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [csf_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [csf_pkg::LEFT_W-1:0]  rd_left;
  logic [csf_pkg::COL_W-1:0]   rd_right;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csf_pkg::ST_IDLE;
      clr_cnt_r   <= '0;
      drawn_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      drawn_r     <= drawn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the command payload for the walk and the pending read.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cx_r  <= in_ch.center_x;
      cy_r  <= in_ch.center_y;
      rad_r <= in_ch.radius;
      row_r <= AW'(in_ch.row);
      oob_r <= (32'(in_ch.row) >= ROWS) || !drawn_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    drawn_nxt     = drawn_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    in_ch.ready   = 1'b0;
    walk_start    = 1'b0;
    case (state_r)
      csf_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.kind == csf_pkg::KIND_DRAW) begin
            state_nxt   = csf_pkg::ST_CLEAR;
            clr_cnt_nxt = '0;
            drawn_nxt   = 1'b1;
          end else begin
            state_nxt = csf_pkg::ST_RESP;
          end
        end
      end
      csf_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(ROWS - 1)) begin
          walk_start = 1'b1;
          state_nxt  = csf_pkg::ST_WALK;
        end
      end
      csf_pkg::ST_WALK: begin
        if (pt.valid && pt.last) begin
          state_nxt = csf_pkg::ST_DRAIN;
        end
      end
      csf_pkg::ST_DRAIN: begin
        // Let the last point's write land before any read.
        state_nxt = csf_pkg::ST_IDLE;
      end
      csf_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = csf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csf_pkg::ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------ draw datapath
  csf_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (walk_start),
    .center_x (cx_r),
    .center_y (cy_r),
    .radius   (rad_r),
    .pt       (pt)
  );

  // Drop points whose row lies off the table.
  assign pt_drop = (pt.row < 0) || (pt.row >= ROWS_C);
  assign iss_we  = (state_r == csf_pkg::ST_WALK) && pt.valid && !pt_drop;

  csf_edge_upd #(
    .ROWS (ROWS)
  ) u_edge_upd (
    .clk      (clk),
    .rst_n    (rst_n),
    .iss_we   (iss_we),
    .iss_addr (pt.row[AW-1:0]),
    .iss_col  (pt.col),
    .rdata    (ram_rdata),
    .we       (upd_we),
    .waddr    (upd_waddr),
    .wdata    (upd_wdata)
  );

  // --------------------------------------------------------------- edge table
  always_comb begin
    if (state_r == csf_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = csf_pkg::ENTRY_EMPTY;
    end else begin
      ram_we    = upd_we;
      ram_waddr = upd_waddr;
      ram_wdata = upd_wdata;
    end
    case (state_r)
      csf_pkg::ST_IDLE: ram_raddr = AW'(in_ch.row);
      csf_pkg::ST_RESP: ram_raddr = row_r;
      default:          ram_raddr = pt.row[AW-1:0];
    endcase
  end

  csf_ram #(
    .WIDTH (csf_pkg::ENTRY_W),
    .DEPTH (ROWS)
  ) u_edge_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ----------------------------------------------------------- result register
  assign rd_left  = oob_r ? csf_pkg::EMPTY_LEFT : csf_pkg::entry_left(ram_rdata);
  assign rd_right = oob_r ? csf_pkg::ZERO_RIGHT : csf_pkg::entry_right(ram_rdata);

  always_ff @(posedge clk) begin
    if ((state_r == csf_pkg::ST_RESP) && out_free) begin
      span_left_r    <= rd_left;
      span_right_r   <= rd_right;
      span_present_r <= (rd_left <= {1'b0, rd_right});
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.span_left    = span_left_r;
  assign out_ch.span_right   = span_right_r;
  assign out_ch.span_present = span_present_r;

  // --------------------------------------------------------------- assertions
  // No table update may land while a read is being served.
  a_no_upd_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == csf_pkg::ST_IDLE) || (state_r == csf_pkg::ST_RESP)) |-> !upd_we)
    else $error("edge update write outside a draw");

  // The walker runs only inside the walk phase.
  a_walk_phase: assert property (@(posedge clk) disable iff (!rst_n)
    pt.valid |-> (state_r == csf_pkg::ST_WALK))
    else $error("walker active outside walk phase");

  // A result appears only after a read was served.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == csf_pkg::ST_RESP))
    else $error("result without a read");

endmodule

`default_nettype wire

### src/csf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
`default_nettype none

module csf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/csf_walker.sv
// Midpoint circle walker: emits one octant point per cycle.
`default_nettype none

module csf_walker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [8:0]           center_x,
  input  wire logic [8:0]           center_y,
  input  wire logic [8:0]           radius,
  output      csf_pkg::point_t      pt
);

  logic              busy_r, busy_nxt;
  logic [2:0]        k_r, k_nxt;
  csf_pkg::coord_t   x_r, x_nxt;
  csf_pkg::coord_t   y_r, y_nxt;
  csf_pkg::coord_t   p_r, p_nxt;
  csf_pkg::coord_t   cx_r, cx_nxt;
  csf_pkg::coord_t   cy_r, cy_nxt;
  csf_pkg::coord_t   col_s;
  csf_pkg::coord_t   row_s;
  csf_pkg::coord_t   x_inc;
  logic              cont;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    p_r  <= p_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
  end

  // Pick the octant point for this slot.
  always_comb begin
    case (k_r)
      3'd0:    begin col_s = cx_r + x_r; row_s = cy_r + y_r; end
      3'd1:    begin col_s = cx_r + y_r; row_s = cy_r + x_r; end
      3'd2:    begin col_s = cx_r + x_r; row_s = cy_r - y_r; end
      3'd3:    begin col_s = cx_r + y_r; row_s = cy_r - x_r; end
      3'd4:    begin col_s = cx_r - x_r; row_s = cy_r + y_r; end
      3'd5:    begin col_s = cx_r - y_r; row_s = cy_r + x_r; end
      3'd6:    begin col_s = cx_r - x_r; row_s = cy_r - y_r; end
      3'd7:    begin col_s = cx_r - y_r; row_s = cy_r - x_r; end
      default: begin col_s = cx_r;       row_s = cy_r;       end
    endcase
  end

  assign cont  = (x_r <= y_r);
  assign x_inc = x_r + csf_pkg::coord_t'(1);

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    p_nxt    = p_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = 3'd0;
      x_nxt    = '0;
      y_nxt    = {5'b0, radius};
      p_nxt    = csf_pkg::coord_t'(1) - {5'b0, radius};
      cx_nxt   = {5'b0, center_x};
      cy_nxt   = {5'b0, center_y};
    end else if (busy_r) begin
      k_nxt = k_r + 3'd1;
      if (k_r == 3'd7) begin
        if (cont) begin
          // Advance one midpoint step.
          x_nxt = x_inc;
          if (p_r < 0) begin
            p_nxt = p_r + (x_inc <<< 1) + csf_pkg::coord_t'(1);
          end else begin
            p_nxt = p_r + ((x_inc - y_r) <<< 1) + csf_pkg::coord_t'(1);
            y_nxt = y_r - csf_pkg::coord_t'(1);
          end
        end else begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    pt.valid = busy_r;
    pt.last  = busy_r && (k_r == 3'd7) && !cont;
    pt.row   = row_s;
    if (col_s < 0) begin
      pt.col = '0;
    end else if (col_s > {5'b0, csf_pkg::COL_MAX}) begin
      pt.col = csf_pkg::COL_MAX;
    end else begin
      pt.col = col_s[csf_pkg::COL_W-1:0];
    end
  end

endmodule

`default_nettype wire

### src/csf_edge_upd.sv
// Edge table read-modify-write stage with one-deep write forwarding.
`default_nettype none

module csf_edge_upd #(
  parameter int ROWS = csf_pkg::ROWS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        iss_we,
  input  wire logic [$clog2(ROWS)-1:0]     iss_addr,
  input  wire logic [csf_pkg::COL_W-1:0]   iss_col,
  input  wire logic [csf_pkg::ENTRY_W-1:0] rdata,
  output      logic                        we,
  output      logic [$clog2(ROWS)-1:0]     waddr,
  output      logic [csf_pkg::ENTRY_W-1:0] wdata
);

  localparam int AW = $clog2(ROWS);

  logic                        s1_we_r;
  logic [AW-1:0]               s1_addr_r;
  logic [csf_pkg::COL_W-1:0]   s1_col_r;
  logic                        fw_valid_r;
  logic [AW-1:0]               fw_addr_r;
  logic [csf_pkg::ENTRY_W-1:0] fw_data_r;
  logic [csf_pkg::ENTRY_W-1:0] cur;
  logic [csf_pkg::LEFT_W-1:0]  cur_left, new_left, col_ext;
  logic [csf_pkg::COL_W-1:0]   cur_right, new_right;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_we_r    <= 1'b0;
      fw_valid_r <= 1'b0;
    end else begin
      s1_we_r    <= iss_we;
      fw_valid_r <= we;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= iss_addr;
    s1_col_r  <= iss_col;
    fw_addr_r <= waddr;
    fw_data_r <= wdata;
  end

  // Take the previous write when it hit the row just read.
  assign cur       = (fw_valid_r && (fw_addr_r == s1_addr_r)) ? fw_data_r : rdata;
  assign cur_left  = csf_pkg::entry_left(cur);
  assign cur_right = csf_pkg::entry_right(cur);
  assign col_ext   = {1'b0, s1_col_r};
  assign new_left  = (col_ext < cur_left) ? col_ext : cur_left;
  assign new_right = (s1_col_r > cur_right) ? s1_col_r : cur_right;

  assign we    = s1_we_r;
  assign waddr = s1_addr_r;
  assign wdata = {new_left, new_right};

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench of the circle scanline fill unit: draw/read words against a span predictor.
`timescale 1ns / 1ps

module tb_top;

  // One command word on the input channel.
  typedef struct packed {
    logic                      kind;
    logic [csf_pkg::COL_W-1:0] center_x;
    logic [csf_pkg::COL_W-1:0] center_y;
    logic [csf_pkg::COL_W-1:0] radius;
    logic [csf_pkg::COL_W-1:0] row;
  } cmd_word_t;

  // One span word on the result channel.
  typedef struct packed {
    logic [csf_pkg::LEFT_W-1:0] left;
    logic [csf_pkg::COL_W-1:0]  right;
    logic                       present;
  } span_t;

  // Directed row: a word plus, where it is obvious, the span it must return.
  typedef struct packed {
    cmd_word_t word;
    logic      typed;
    span_t     span;
  } script_row_t;

  localparam span_t EMPTY_SPAN = '{csf_pkg::EMPTY_LEFT, csf_pkg::ZERO_RIGHT, 1'b0};
  localparam span_t NO_SPAN    = '0;
  localparam int    WORDS_TOTAL = 660;
  localparam int    TAIL_START  = 600;   // no idling on either side past this word
  localparam int    SCRIPT_LEN  = 24;

  logic clk = 1'b0;
  logic rst_n;

  csf_in_if  in_ch ();
  csf_out_if out_ch ();

  circle_scanline_fill_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Edge tables as the predictor sees them, and the spans still owed by the unit.
  logic [csf_pkg::LEFT_W-1:0] row_left  [csf_pkg::ROWS_DEF];
  logic [csf_pkg::COL_W-1:0]  row_right [csf_pkg::ROWS_DEF];
  span_t                      pending_spans [$];

  int unsigned fault_cnt    = 0;
  int unsigned spans_seen   = 0;
  int unsigned words_sent   = 0;
  bit          steady_tail  = 1'b0;

  // Directed part: reset contents, off-table rows, saturated columns, both kinds.
  script_row_t script [SCRIPT_LEN] = '{
    // Until the first draw every row reads empty.
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd0},   1'b1, EMPTY_SPAN},
    '{'{csf_pkg::KIND_READ, 9'h1FF, 9'h1FF, 9'h1FF, 9'd255}, 1'b1, EMPTY_SPAN},
    '{'{csf_pkg::KIND_READ, 9'h0AA, 9'h155, 9'h0F0, 9'd511}, 1'b1, EMPTY_SPAN},
    // Radius zero at the origin: negative rows drop, negative columns clamp to 0.
    '{'{csf_pkg::KIND_DRAW, 9'd0,   9'd0,   9'd0,   9'h155}, 1'b0, NO_SPAN},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd0},   1'b1, '{10'd0, 9'd0, 1'b1}},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd1},   1'b0, NO_SPAN},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd511}, 1'b1, EMPTY_SPAN},
    // Largest everything: rows past the table drop, columns clamp to 511.
    '{'{csf_pkg::KIND_DRAW, 9'd511, 9'd511, 9'd511, 9'h1FF}, 1'b0, NO_SPAN},
    '{'{csf_pkg::KIND_READ, 9'h1FF, 9'h1FF, 9'h1FF, 9'd0},   1'b0, NO_SPAN},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd511}, 1'b1, '{10'd0, 9'd511, 1'b1}},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd300}, 1'b0, NO_SPAN},
    // Circle well inside the raster.
    '{'{csf_pkg::KIND_DRAW, 9'd256, 9'd256, 9'd100, 9'd0},   1'b0, NO_SPAN},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd155}, 1'b1, EMPTY_SPAN},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd156}, 1'b0, NO_SPAN},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd256}, 1'b1, '{10'd156, 9'd356, 1'b1}},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd356}, 1'b0, NO_SPAN},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd357}, 1'b1, EMPTY_SPAN},
    // Radius one at the top right corner.
    '{'{csf_pkg::KIND_DRAW, 9'd511, 9'd0,   9'd1,   9'd0},   1'b0, NO_SPAN},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd0},   1'b0, NO_SPAN},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd1},   1'b0, NO_SPAN},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd2},   1'b1, EMPTY_SPAN},
    // Largest radius from the middle covers every row.
    '{'{csf_pkg::KIND_DRAW, 9'd256, 9'd256, 9'd511, 9'd0},   1'b0, NO_SPAN},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd0},   1'b0, NO_SPAN},
    '{'{csf_pkg::KIND_READ, 9'd0,   9'd0,   9'd0,   9'd511}, 1'b0, NO_SPAN}
  };

  // ---------------------------------------------------------------------------
  // Span predictor
  // ---------------------------------------------------------------------------

  // Widen one row by one outline point; drop rows off the table, clamp columns.
  function automatic void widen_row(input int col, input int r);
    logic [csf_pkg::COL_W-1:0] c;
    if (r < 0 || r >= csf_pkg::ROWS_DEF) return;
    if (col < 0) col = 0;
    if (col > int'(csf_pkg::COL_MAX)) col = int'(csf_pkg::COL_MAX);
    c = csf_pkg::COL_W'(col);
    if ({1'b0, c} < row_left[r]) row_left[r] = {1'b0, c};
    if (c > row_right[r]) row_right[r] = c;
  endfunction

  function automatic void plot_octants(input int x, input int y, input int cx, input int cy);
    widen_row(cx + x, cy + y);
    widen_row(cx + y, cy + x);
    widen_row(cx + x, cy - y);
    widen_row(cx + y, cy - x);
    widen_row(cx - x, cy + y);
    widen_row(cx - y, cy + x);
    widen_row(cx - x, cy - y);
    widen_row(cx - y, cy - x);
  endfunction

  // Clear both tables, then walk the midpoint circle into them.
  function automatic void trace_circle(input int cx, input int cy, input int rad);
    int i;
    int p;
    int x;
    int y;
    for (i = 0; i < csf_pkg::ROWS_DEF; i++) begin
      row_left[i]  = csf_pkg::EMPTY_LEFT;
      row_right[i] = csf_pkg::ZERO_RIGHT;
    end
    p = 1 - rad;
    x = 0;
    y = rad;
    plot_octants(x, y, cx, cy);
    while (x <= y) begin
      x++;
      if (p < 0) begin
        p += 2 * x + 1;
      end else begin
        p += 2 * (x - y) + 1;
        y--;
      end
      plot_octants(x, y, cx, cy);
    end
  endfunction

  function automatic span_t read_span(input logic [csf_pkg::COL_W-1:0] r);
    span_t s;
    s.left    = row_left[r];
    s.right   = row_right[r];
    s.present = (row_left[r] <= {1'b0, row_right[r]});
    return s;
  endfunction

  function automatic void note_fault(input string what);
    fault_cnt++;
    if (fault_cnt <= 10) $display("%s", what);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until taken, then fold it into the predictor.
  // A burst of idle cycles may come first; valid gets one assignment per step.
  task automatic offer_word(input cmd_word_t w, input bit typed, input span_t typed_span,
                            input bit may_idle);
    if (may_idle && !steady_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= w.kind;
    in_ch.center_x <= w.center_x;
    in_ch.center_y <= w.center_y;
    in_ch.radius   <= w.radius;
    in_ch.row      <= w.row;
    do @(posedge clk); while (!in_ch.ready);
    if (w.kind == csf_pkg::KIND_DRAW) begin
      trace_circle(int'(w.center_x), int'(w.center_y), int'(w.radius));
    end else begin
      pending_spans.push_back(typed ? typed_span : read_span(w.row));
    end
    words_sent++;
    if (words_sent >= TAIL_START) steady_tail = 1'b1;
  endtask

  initial begin
    cmd_word_t w;
    int        rad;
    int        off;
    int        n;
    int        k;
    int        pick;
    bit        may_idle;

    in_ch.valid    <= 1'b0;
    in_ch.kind     <= csf_pkg::KIND_DRAW;
    in_ch.center_x <= '0;
    in_ch.center_y <= '0;
    in_ch.radius   <= '0;
    in_ch.row      <= '0;
    rst_n          <= 1'b0;
    trace_circle(0, 0, 0);
    // Reset contents are all empty; the draw above is only a quick way to clear.
    for (k = 0; k < csf_pkg::ROWS_DEF; k++) begin
      row_left[k]  = csf_pkg::EMPTY_LEFT;
      row_right[k] = csf_pkg::ZERO_RIGHT;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) offer_word(script[i].word, script[i].typed, script[i].span, 1'b1);

    // Random part: mostly a draw followed by reads of rows around that circle,
    // with some groups of unrelated noise words.
    while (words_sent < WORDS_TOTAL) begin
      may_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) != 0) begin
        w.kind = csf_pkg::KIND_DRAW;
        pick   = $urandom_range(0, 99);
        if (pick < 60)      rad = $urandom_range(0, 15);
        else if (pick < 85) rad = $urandom_range(16, 127);
        else if (pick < 95) rad = $urandom_range(128, 300);
        else                rad = $urandom_range(301, 511);
        w.radius = csf_pkg::COL_W'(rad);
        // Pull the center to a raster border now and then, so points fall off.
        w.center_x = ($urandom_range(0, 4) == 0) ?
                     ($urandom_range(0, 1) ? csf_pkg::COL_W'($urandom_range(0, 7)) :
                                             csf_pkg::COL_W'($urandom_range(504, 511))) :
                     csf_pkg::COL_W'($urandom);
        w.center_y = ($urandom_range(0, 4) == 0) ?
                     ($urandom_range(0, 1) ? csf_pkg::COL_W'($urandom_range(0, 7)) :
                                             csf_pkg::COL_W'($urandom_range(504, 511))) :
                     csf_pkg::COL_W'($urandom);
        w.row = csf_pkg::COL_W'($urandom);
        offer_word(w, 1'b0, NO_SPAN, may_idle);
        n = $urandom_range(3, 10);
        for (k = 0; k < n; k++) begin
          off = $urandom_range(0, 2 * rad + 4) - (rad + 2);
          w.kind     = csf_pkg::KIND_READ;
          w.row      = csf_pkg::COL_W'(int'(w.center_y) + off);
          w.radius   = csf_pkg::COL_W'($urandom);
          offer_word(w, 1'b0, NO_SPAN, may_idle);
        end
      end else begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          w = cmd_word_t'($bits(cmd_word_t)'({$urandom, $urandom}));
          // Keep noise draws short; the big radii come from the groups above.
          if (w.kind == csf_pkg::KIND_DRAW) w.radius = csf_pkg::COL_W'($urandom_range(0, 63));
          offer_word(w, 1'b0, NO_SPAN, may_idle);
        end
      end
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every owed span, then give a trailing draw time to finish
    // so a stray result would still show up.
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("circle_scanline_fill_unit regression: pass");
    end else begin
      $display("circle_scanline_fill_unit regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off so the unit backs up its input,
  // and no stalls in the tail.
  // ---------------------------------------------------------------------------
  initial begin
    bit held_once;
    held_once = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_once && spans_seen >= 40) begin
        held_once = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!steady_tail && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Span checker: compare each taken word with the oldest owed span.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    span_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      spans_seen++;
      if (pending_spans.size() == 0) begin
        note_fault($sformatf("span word with none owed: left=%0d right=%0d present=%0d",
                             out_ch.span_left, out_ch.span_right, out_ch.span_present));
      end else begin
        want = pending_spans.pop_front();
        if (out_ch.span_left !== want.left || out_ch.span_right !== want.right ||
            out_ch.span_present !== want.present) begin
          note_fault($sformatf({"span mismatch at %0t: expected left=%0d right=%0d ",
                                "present=%0d, got left=%0d right=%0d present=%0d"},
                               $realtime, want.left, want.right, want.present,
                               out_ch.span_left, out_ch.span_right, out_ch.span_present));
        end
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #50_000_000;
    $display("circle_scanline_fill_unit regression: fail");
    $finish;
  end

endmodule

### filelist.f
src/csf_pkg.sv
src/csf_if.sv
src/csf_ram.sv
src/csf_walker.sv
src/csf_edge_upd.sv
src/circle_scanline_fill_unit.sv
tb/tb_top.sv
